// ----- hdl/ssa_pkg.sv -----
// Set statistic aggregator: shared types and constants.
// No dependencies; imported by the aggregator core.
package ssa_pkg;

    localparam int VALUE_W    = 32;
    localparam int SET_SIZE_W = 9;
    localparam int MODE_W     = 3;
    localparam int OUT_DATA_W = 48;   // value + set size, padded to whole bytes
    localparam int OUT_PAD_W  = OUT_DATA_W - VALUE_W - SET_SIZE_W;

    localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MEDIAN = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MIN    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MAX    = 3'd3;

    typedef enum logic [3:0] {
        ST_LOAD,       // collecting values, one per cycle
        ST_DIV_GO,     // launch divider for mean
        ST_DIV_WAIT,   // wait for quotient
        ST_CAND,       // issue read of median candidate
        ST_CAND_LAT,   // latch candidate value
        ST_SCAN,       // stream whole set past the comparator
        ST_RANK,       // check candidate rank against middle ranks
        ST_FIRST,      // read of entry zero in flight
        ST_RESULT      // hand result to output register
    } ssa_state_t;

endpackage

// ----- hdl/ssa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/ssa_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies; used by the aggregator core for the mean.
module ssa_divider #(
    parameter int DIVIDEND_W = 40,
    parameter int DIVISOR_W  = 9
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // shift in next dividend bit, subtract if divisor fits
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : DIVISOR_W'(trial);
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/set_statistic_aggregator_core.sv -----
// Set statistic aggregator top level: loads a set of Q24.8 values and emits one statistic.
// Depends on ssa_pkg, ssa_ram and ssa_divider.
//
// Values arrive one per transfer on the slave stream, the set closed by tlast; while
// loading, one transfer is taken every cycle. On the closing transfer the block stops
// taking input and computes the statistic chosen by the mode register (0 mean, 1 median,
// 2 minimum, 3 maximum, 4..7 first value). Minimum and maximum are tracked on the fly;
// first value takes one read of the value store. Mean runs a bit-serial restoring divider
// over the running sum. Median is found by rank counting through the single read port of
// the value store: each candidate takes one full scan of the set through one comparator,
// and up to n candidates are tried for a set of n values. The result waits in an output
// register, so loading of the next set starts as soon as the result is in that register.
// Values beyond MAX_VALUES are dropped and reported through the overflow flag. There is
// no clearing pass: only entries written in the current set are ever read.
module set_statistic_aggregator_core #(
    parameter int MAX_VALUES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: collapse mode
    input  logic                          cfg_we,
    input  logic [ssa_pkg::MODE_W-1:0]    cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ssa_pkg::VALUE_W-1:0]   s_tdata,   // [31:0] sample_value
    input  logic                          s_tlast,   // last_sample
    // output stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ssa_pkg::OUT_DATA_W-1:0] m_tdata,  // [31:0] collapsed_value,
                                                     // [40:32] set_size, [47:41] zero
    output logic                          m_tuser    // overflowed
);

    import ssa_pkg::*;

    localparam int IW   = $clog2(MAX_VALUES);        // store address width
    localparam int CW   = $clog2(MAX_VALUES + 1);    // count width, holds MAX_VALUES
    localparam int SUMW = VALUE_W + CW;              // running sum width

    ssa_state_t           state_reg, state_next;
    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [SUMW-1:0]      sum_reg, sum_next;
    logic [VALUE_W-1:0]   min_reg, min_next;
    logic [VALUE_W-1:0]   max_reg, max_next;
    logic                 drop_reg, drop_next;

    // median search
    logic [IW-1:0]        cand_idx_reg, cand_idx_next;
    logic [VALUE_W-1:0]   cand_val_reg, cand_val_next;
    logic [CW-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]        less_reg, less_next;
    logic [CW-1:0]        le_reg, le_next;
    logic                 lo_found_reg, lo_found_next;
    logic                 hi_found_reg, hi_found_next;
    logic [VALUE_W-1:0]   lo_val_reg, lo_val_next;
    logic [VALUE_W-1:0]   hi_val_reg, hi_val_next;

    // output register
    logic                 out_vld_reg, out_vld_next;
    logic [VALUE_W-1:0]   out_val_reg, out_val_next;
    logic [SET_SIZE_W-1:0] out_size_reg, out_size_next;
    logic                 out_ovf_reg, out_ovf_next;

    logic                 in_xfer;
    logic                 has_room;
    logic                 ram_we;
    logic [IW-1:0]        ram_rd_addr;
    logic [VALUE_W-1:0]   ram_rd_data;
    logic                 div_start;
    logic                 div_done;
    logic [SUMW-1:0]      div_quo;
    logic                 val_lt;
    logic                 val_eq;
    logic [CW-1:0]        k_lo;
    logic [CW-1:0]        k_hi;
    logic                 lo_hit;
    logic                 hi_hit;
    logic [VALUE_W:0]     mid_sum;
    logic [VALUE_W-1:0]   med_val;
    logic [VALUE_W-1:0]   res_val;

    assign s_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign has_room = (cnt_reg < CW'(MAX_VALUES));
    assign ram_we   = in_xfer && has_room;

    ssa_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_VALUES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg[IW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign div_start = (state_reg == ST_DIV_GO);

    ssa_divider #(
        .DIVIDEND_W (SUMW),
        .DIVISOR_W  (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // single comparator shared by the whole rank scan
    assign val_lt = ram_rd_data < cand_val_reg;
    assign val_eq = ram_rd_data == cand_val_reg;

    // middle ranks (0-based); equal for odd set sizes
    assign k_lo   = (cnt_reg - 1'b1) >> 1;
    assign k_hi   = cnt_reg >> 1;
    assign lo_hit = (less_reg <= k_lo) && (k_lo < le_reg);
    assign hi_hit = (less_reg <= k_hi) && (k_hi < le_reg);

    assign mid_sum = {1'b0, lo_val_reg} + {1'b0, hi_val_reg};
    assign med_val = mid_sum[VALUE_W:1];

    // read address: candidate, scan position, else entry zero for first-value mode
    always_comb
    begin
        case (state_reg)
            ST_CAND: ram_rd_addr = cand_idx_reg;
            ST_SCAN: ram_rd_addr = scan_cnt_reg[IW-1:0];
            default: ram_rd_addr = '0;
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            MODE_MEAN:   res_val = div_quo[VALUE_W-1:0];
            MODE_MEDIAN: res_val = med_val;
            MODE_MIN:    res_val = min_reg;
            MODE_MAX:    res_val = max_reg;
            default:     res_val = ram_rd_data;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = cfg_we ? cfg_wdata : mode_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        min_next      = min_reg;
        max_next      = max_reg;
        drop_next     = drop_reg;
        cand_idx_next = cand_idx_reg;
        cand_val_next = cand_val_reg;
        scan_cnt_next = scan_cnt_reg;
        cmp_vld_next  = 1'b0;
        less_next     = less_reg;
        le_next       = le_reg;
        lo_found_next = lo_found_reg;
        hi_found_next = hi_found_reg;
        lo_val_next   = lo_val_reg;
        hi_val_next   = hi_val_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_val_next  = out_val_reg;
        out_size_next = out_size_reg;
        out_ovf_next  = out_ovf_reg;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (has_room)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        sum_next = sum_reg + SUMW'(s_tdata);
                        if (s_tdata < min_reg)
                        begin
                            min_next = s_tdata;
                        end
                        if (s_tdata > max_reg)
                        begin
                            max_next = s_tdata;
                        end
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        case (mode_reg)
                            MODE_MEAN:   state_next = ST_DIV_GO;
                            MODE_MEDIAN: state_next = ST_CAND;
                            MODE_MIN:    state_next = ST_RESULT;
                            MODE_MAX:    state_next = ST_RESULT;
                            default:     state_next = ST_FIRST;
                        endcase
                        cand_idx_next = '0;
                        lo_found_next = 1'b0;
                        hi_found_next = 1'b0;
                    end
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_CAND:
            begin
                state_next = ST_CAND_LAT;
            end
            ST_CAND_LAT:
            begin
                cand_val_next = ram_rd_data;
                scan_cnt_next = '0;
                less_next     = '0;
                le_next       = '0;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                // issue one read per cycle, compare data of the previous read
                if (scan_cnt_reg < cnt_reg)
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                    cmp_vld_next  = 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    if (val_lt)
                    begin
                        less_next = less_reg + 1'b1;
                    end
                    if (val_lt || val_eq)
                    begin
                        le_next = le_reg + 1'b1;
                    end
                end
                if ((scan_cnt_reg == cnt_reg) && !cmp_vld_reg)
                begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK:
            begin
                if (!lo_found_reg && lo_hit)
                begin
                    lo_found_next = 1'b1;
                    lo_val_next   = cand_val_reg;
                end
                if (!hi_found_reg && hi_hit)
                begin
                    hi_found_next = 1'b1;
                    hi_val_next   = cand_val_reg;
                end
                if ((lo_found_reg || lo_hit) && (hi_found_reg || hi_hit))
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    cand_idx_next = cand_idx_reg + 1'b1;
                    state_next    = ST_CAND;
                end
            end
            ST_FIRST:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_val_next  = res_val;
                    out_size_next = SET_SIZE_W'(cnt_reg);
                    out_ovf_next  = drop_reg;
                    cnt_next      = '0;
                    sum_next      = '0;
                    min_next      = '1;
                    max_next      = '0;
                    drop_next     = 1'b0;
                    state_next    = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            mode_reg     <= MODE_MEAN;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            min_reg      <= '1;
            max_reg      <= '0;
            drop_reg     <= 1'b0;
            cmp_vld_reg  <= 1'b0;
            lo_found_reg <= 1'b0;
            hi_found_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            min_reg      <= min_next;
            max_reg      <= max_next;
            drop_reg     <= drop_next;
            cmp_vld_reg  <= cmp_vld_next;
            lo_found_reg <= lo_found_next;
            hi_found_reg <= hi_found_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_idx_reg <= cand_idx_next;
        cand_val_reg <= cand_val_next;
        scan_cnt_reg <= scan_cnt_next;
        less_reg     <= less_next;
        le_reg       <= le_next;
        lo_val_reg   <= lo_val_next;
        hi_val_reg   <= hi_val_next;
        out_val_reg  <= out_val_next;
        out_size_reg <= out_size_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_size_reg, out_val_reg};
    assign m_tuser  = out_ovf_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_VALUES))
        else $error("stored count beyond capacity");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= cnt_reg))
        else $error("rank scan ran past the set");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside mean computation");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RESULT) && (mode_reg == MODE_MEAN)) |->
            (div_quo <= SUMW'(max_reg)))
        else $error("mean above set maximum");

    a_median_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RESULT) && (mode_reg == MODE_MEDIAN)) |->
            ((med_val >= min_reg) && (med_val <= max_reg)))
        else $error("median outside set range");
`endif

endmodule

// ----- test/set_statistic_aggregator_core_test.sv -----
// Self-checking testbench for set_statistic_aggregator_core: sets of Q24.8 values in,
// one statistic per set out, checked against a built-in predictor under every mode.
// Depends on ssa_pkg and the core; needs no files or arguments.
module set_statistic_aggregator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ssa_pkg::*;

    localparam int SET_CAP = 256;
    localparam logic [MODE_W-1:0] MODE_FIRST = 3'd4;   // 5..7 also act as first value

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } sample_t;

    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [SET_SIZE_W-1:0] set_size;
        logic                  overflowed;
    } stat_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [MODE_W-1:0]     cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata = '0;   // [31:0] sample_value
    logic                  s_tlast = 1'b0; // last_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // [31:0] collapsed_value, [40:32] set_size
    logic                  m_tuser;        // overflowed

    sample_t pending_samples[$];   // waiting to be driven
    stat_t   pending_stats[$];     // predicted, not yet seen on the output
    sample_t next_sample;
    int      burst_left = 0;
    int      gap_left = 0;
    int      ready_left = 0;
    int      mismatch_count = 0;

    // predictor state
    logic [MODE_W-1:0]  collapse_sel = MODE_MEAN;
    logic [VALUE_W-1:0] held_vals [SET_CAP];
    int unsigned        held_count = 0;
    logic [39:0]        sum_acc = '0;
    logic [VALUE_W-1:0] min_acc = '1;
    logic [VALUE_W-1:0] max_acc = '0;
    logic               dropped = 1'b0;

    set_statistic_aggregator_core #(
        .MAX_VALUES(SET_CAP)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // Middle element by rank; even counts average the two middle ones (truncated).
    function automatic logic [VALUE_W-1:0] median_of_held();
        logic [VALUE_W-1:0] ranked [SET_CAP];
        logic [VALUE_W-1:0] v;
        logic [VALUE_W:0]   pair;
        int unsigned        n;
        int unsigned        j;
        n = held_count;
        for (int i = 0; i < n; i++)
            ranked[i] = held_vals[i];
        for (int i = 1; i < n; i++)
        begin
            v = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > v)
            begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = v;
        end
        if (n[0])
            return ranked[n/2];
        pair = {1'b0, ranked[n/2-1]} + {1'b0, ranked[n/2]};
        return pair[VALUE_W:1];
    endfunction

    // One accepted transfer: store it, and on tlast predict the statistic and clear.
    function automatic void take_sample(logic [VALUE_W-1:0] v, logic is_last);
        stat_t       res;
        logic [39:0] quotient;
        if (held_count < SET_CAP)
        begin
            held_vals[held_count] = v;
            held_count++;
            sum_acc += 40'(v);
            if (v < min_acc) min_acc = v;
            if (v > max_acc) max_acc = v;
        end
        else
            dropped = 1'b1;   // beyond capacity, tlast still closes the set
        if (!is_last)
            return;
        res.set_size   = held_count[SET_SIZE_W-1:0];
        res.overflowed = dropped;
        if (held_count == 0)
            res.value = '0;
        else
            case (collapse_sel)
                MODE_MEAN:
                begin
                    quotient  = sum_acc / 40'(held_count);
                    res.value = quotient[VALUE_W-1:0];
                end
                MODE_MEDIAN: res.value = median_of_held();
                MODE_MIN:    res.value = min_acc;
                MODE_MAX:    res.value = max_acc;
                default:     res.value = held_vals[0];
            endcase
        pending_stats.push_back(res);
        held_count = 0;
        sum_acc    = '0;
        min_acc    = '1;
        max_acc    = '0;
        dropped    = 1'b0;
    endfunction

    function automatic void flag_mismatch(string what, stat_t want, stat_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected value %h size %0d ovf %b, got value %h size %0d ovf %b",
                     $realtime, what, want.value, want.set_size, want.overflowed,
                     got.value, got.set_size, got.overflowed);
    endfunction

    // ---------------------------------------------------------------- driver

    // Bursts of random length, random gaps between them (often none).
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tlast    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left > 0 || pending_samples.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                next_sample = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_sample.value;
                s_tlast  <= next_sample.last;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver: alternating ready runs and stalls, now and then a long ready stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_left <= 0;
        end
        else if (ready_left == 0)
        begin
            m_tready   <= ~m_tready;
            if (m_tready)
                ready_left <= $urandom_range(0, 20);
            else
                ready_left <= ($urandom_range(0, 7) == 0) ? 400 : $urandom_range(0, 30);
        end
        else
            ready_left <= ready_left - 1;
    end

    // ---------------------------------------------------------------- monitor

    // Input transfers feed the predictor, output transfers are checked in order.
    always @(posedge clk)
    begin
        stat_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                take_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got.value      = m_tdata[VALUE_W-1:0];
                got.set_size   = m_tdata[VALUE_W +: SET_SIZE_W];
                got.overflowed = m_tuser;
                if (pending_stats.size() == 0)
                    flag_mismatch("unexpected result", '0, got);
                else if (pending_stats[0] != got)
                    flag_mismatch("mismatch", pending_stats.pop_front(), got);
                else
                    void'(pending_stats.pop_front());
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return VALUE_W'($urandom_range(0, 15));   // plenty of ties
            4:       return VALUE_W'(1) << $urandom_range(0, VALUE_W-1);
            5:       return ~(VALUE_W'(1) << $urandom_range(0, VALUE_W-1));
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_sample(logic [VALUE_W-1:0] v, logic is_last);
        sample_t s;
        s.value = v;
        s.last  = is_last;
        pending_samples.push_back(s);
    endfunction

    function automatic void queue_set(int unsigned n);
        for (int i = 0; i < n; i++)
            push_sample(random_value(), i == n - 1);
    endfunction

    // Mostly small sets; median cost grows with the square of the size.
    function automatic int unsigned pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(1, 6);
        if (r < 85) return $urandom_range(7, 24);
        if (r < 99) return $urandom_range(25, 64);
        return $urandom_range(250, 260);
    endfunction

    // Wait until everything sent has been answered, then let the core go idle.
    task automatic settle();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || s_tvalid || pending_stats.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] m);
        settle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        collapse_sel = m;
    endtask

    initial
    begin
        logic [MODE_W-1:0] mode;
        int unsigned       phase_items;
        int unsigned       n;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: mean at reset value, single item and sum past 32 bits
        push_sample('1, 1'b1);
        push_sample('1, 1'b0);
        push_sample('1, 1'b0);
        push_sample(32'hFFFF_FFFE, 1'b1);
        // median: even count with ties, then two middle values whose sum overflows
        write_mode(MODE_MEDIAN);
        push_sample(32'd7, 1'b0);
        push_sample(32'd3, 1'b0);
        push_sample(32'd3, 1'b0);
        push_sample('1, 1'b1);
        push_sample('1, 1'b0);
        push_sample('1, 1'b1);
        write_mode(MODE_MIN);
        push_sample(32'd5, 1'b0);
        push_sample(32'd0, 1'b0);
        push_sample(32'd9, 1'b1);
        write_mode(MODE_MAX);
        push_sample(32'd0, 1'b0);
        push_sample('1, 1'b0);
        push_sample(32'd1, 1'b1);
        write_mode(MODE_FIRST);
        push_sample(32'hAAAA_AAAA, 1'b0);
        push_sample(32'h5555_5555, 1'b0);
        push_sample(32'd0, 1'b1);

        // random phases: every mode code in turn, then a few random ones
        for (int p = 0; p < 12; p++)
        begin
            mode = (p < 8) ? MODE_W'(p) : MODE_W'($urandom_range(0, 7));
            write_mode(mode);
            if (p < 8)
                case (mode)
                    MODE_MEAN:   queue_set(SET_CAP);       // exactly full
                    MODE_MEDIAN: queue_set(SET_CAP + 2);   // overflow, last two dropped
                    MODE_MAX:    queue_set(SET_CAP + 1);
                    default:     ;
                endcase
            phase_items = 0;
            while (phase_items < 20)
            begin
                n = pick_size();
                queue_set(n);
                phase_items += n;
            end
        end

        settle();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && pending_stats.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, large median sets included.
    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
